// File: hw/rtl/skdmt_pkg.sv
// Shared types and constants for the string-keyed direct-mapped table.
package skdmt_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int HASH_W        = 64;
    localparam int SIZE_W        = 9;
    localparam int CFG_IDX_W     = 1;
    localparam int MOD_STEP_BITS = 8;
    localparam int MOD_STEPS     = HASH_W / MOD_STEP_BITS;

    localparam logic [SIZE_W-1:0]    TABLE_SIZE_RESET = 9'd256;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POINTER_MODE = 1'b1;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_GET     = 3'd1,
        OP_FILL    = 3'd2,
        OP_SET_PTR = 3'd3,
        OP_GET_PTR = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_MODE_ERR = 2'd1,
        STS_NULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        key_char;
        logic              key_last;
        logic [HASH_W-1:0] write_value;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] read_value;
        logic [7:0]  slot_index;
    } out_item_t;

endpackage

// File: hw/rtl/skdmt_ram.sv
// Generic single-port synchronous RAM with registered read.
module skdmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/skdmt_mod.sv
// Iterative 64-bit modulo by a 9-bit divisor, eight dividend bits per cycle.
module skdmt_mod
    import skdmt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SIZE_W-1:0] remainder
);

    localparam int CNT_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;

    always_comb begin
        logic [SIZE_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < MOD_STEP_BITS; i++) begin
            trial = {rem_next, dvd_reg[HASH_W-1-i]};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[SIZE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= dvd_reg << MOD_STEP_BITS;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MOD_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (remainder < divisor))
        else $error("remainder not below divisor");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("modulo restarted while busy");
`endif

endmodule

// File: hw/rtl/string_keyed_direct_mapped_table_unit.sv
// String-keyed direct-mapped table: top level.
//
// Input channel s_*: one key byte per transfer; key_last marks the byte that
// carries the opcode and triggers the table operation. A non-final byte updates
// the hash (hash = hash*97 + byte; a zero byte leaves it unchanged) and
// produces no result. Result channel m_*: one transfer per key. After the
// final byte the 64-bit hash is reduced modulo the table size by an iterative
// unit; then set writes the slot, get/get_ptr read it, fill writes every entry
// below the table size, and a mode error touches none.
// The RAM port (one access a cycle) paces fill and the clearing pass.
// Configuration: cfg_we/cfg_index/cfg_wdata; the user must write these only
// while idle (the block does not enforce this). Reset (aresetn low, synchronous)
// clears the hash and control state, then a clearing pass writes zero into all
// TABLE_DEPTH entries, one per cycle; s_ready stays low until the pass is done.
// A finished result sits in the output register until m_ready; meanwhile the
// block keeps taking key bytes and holds the next result until the register
// is free.
module string_keyed_direct_mapped_table_unit
    import skdmt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_wdata
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_FILL,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic [HASH_W-1:0]      hash_next;
    opcode_t                op_reg;
    logic [VALUE_WIDTH-1:0] wval_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [SIZE_W-1:0]      fill_cnt_reg;
    logic [SIZE_W-1:0]      tsize_reg;
    logic                   ptr_mode_reg;
    out_item_t              res_reg;
    out_item_t              m_data_reg;
    logic                   m_valid_reg;

    logic [SIZE_W-1:0]      eff_size;
    logic                   s_xfer;
    logic                   mod_start;
    logic                   mod_done;
    logic [SIZE_W-1:0]      mod_rem;
    logic [ADDR_W-1:0]      slot_addr;
    logic [7:0]             slot_idx;
    logic                   val_op;
    logic                   ptr_op;
    logic                   mode_err;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign mod_start = s_xfer && s_data.key_last;

    assign hash_next = (s_data.key_char != 8'd0)
                     ? (hash_reg << 6) + (hash_reg << 5) + hash_reg + HASH_W'(s_data.key_char)
                     : hash_reg;

    always_comb begin
        if (tsize_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (32'(tsize_reg) > 32'(TABLE_DEPTH)) begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end else begin
            eff_size = tsize_reg;
        end
    end

    skdmt_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (hash_next),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign slot_addr = ADDR_W'(mod_rem);
    assign slot_idx  = (op_reg == OP_FILL) ? 8'd0 : mod_rem[7:0];

    always_comb begin
        val_op = 1'b0;
        ptr_op = 1'b0;
        case (op_reg) inside
            OP_SET, OP_GET, OP_FILL: val_op = 1'b1;
            OP_SET_PTR, OP_GET_PTR:  ptr_op = 1'b1;
            default: ;
        endcase
    end

    assign mode_err = ptr_mode_reg ? !ptr_op : !val_op;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = slot_addr;
        ram_wdata = wval_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_MOD: begin
                ram_we = mod_done && !mode_err && (op_reg == OP_SET || op_reg == OP_SET_PTR);
            end
            S_FILL: begin
                ram_we   = 1'b1;
                ram_addr = ADDR_W'(fill_cnt_reg);
            end
            default: ;
        endcase
    end

    skdmt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tsize_reg    <= TABLE_SIZE_RESET;
            ptr_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TABLE_SIZE:   tsize_reg    <= cfg_wdata;
                REG_POINTER_MODE: ptr_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            hash_reg     <= '0;
            op_reg       <= OP_SET;
            wval_reg     <= '0;
            clr_cnt_reg  <= '0;
            fill_cnt_reg <= '0;
            res_reg      <= '0;
            m_data_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_xfer) begin
                        if (s_data.key_last) begin
                            hash_reg  <= '0;
                            op_reg    <= opcode_t'(s_data.opcode);
                            wval_reg  <= s_data.write_value[VALUE_WIDTH-1:0];
                            state_reg <= S_MOD;
                        end else begin
                            hash_reg <= hash_next;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        res_reg.status     <= mode_err ? STS_MODE_ERR : STS_OK;
                        res_reg.read_value <= '0;
                        res_reg.slot_index <= slot_idx;
                        if (mode_err || op_reg == OP_SET || op_reg == OP_SET_PTR) begin
                            state_reg <= S_OUT;
                        end else if (op_reg == OP_FILL) begin
                            fill_cnt_reg <= '0;
                            state_reg    <= S_FILL;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    res_reg.read_value <= 64'(ram_rdata);
                    if (op_reg == OP_GET_PTR && ram_rdata == '0) begin
                        res_reg.status <= STS_NULL;
                    end
                    state_reg <= S_OUT;
                end
                S_FILL: begin
                    fill_cnt_reg <= fill_cnt_reg + 1'b1;
                    if (fill_cnt_reg == eff_size - 1'b1) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == S_MOD))
        else $error("modulo result outside modulo wait");

    a_hash_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_start |=> (hash_reg == '0))
        else $error("hash not cleared after final byte");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (fill_cnt_reg < eff_size))
        else $error("fill beyond table size");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside output state");
`endif

endmodule
